// File: rtl/core/signed_int_to_decimal_ascii_unit_macros.svh
// assertion macros shared by the signed integer to decimal text unit
// no dependencies; included by the top-level module, which carries the assertions
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication
`define SITOA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sitoa assertion failed");

// next-cycle implication
`define SITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sitoa assertion failed");

`endif

// File: rtl/core/sitoa_pkg.sv
// types and constants of the signed integer to decimal text unit
// no dependencies; used by the interfaces, the digit cell, the digit chain and the top level
`default_nettype none

package sitoa_pkg;

  localparam int MAG_W     = 32;
  localparam int BIT_CNT_W = $clog2(MAG_W);
  localparam int NUM_DIGITS = 10;
  localparam int REM_W     = $clog2(NUM_DIGITS + 1);
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [3:0] bcd_t;

  typedef struct packed {
    logic clr;
    logic dabble;
    logic rotate;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CONV   = 4'b0010,
    ST_SIGN   = 4'b0100,
    ST_DIGITS = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/sitoa_if.sv
// valid/ready channel interfaces for the input value and the output text
// depends on sitoa_pkg
`default_nettype none

interface sitoa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [sitoa_pkg::MAG_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sitoa_out_if;
  logic                              valid;
  logic                              ready;
  logic [sitoa_pkg::CHAR_W-1:0]      character;
  logic                              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/sitoa_digit_cell.sv
// one bcd digit cell: add-3 adjust and shift during conversion, digit hand-off during output
// depends on sitoa_pkg
`default_nettype none

module sitoa_digit_cell (
  input  wire logic                  clk,
  input  wire sitoa_pkg::cell_ctrl_t ctrl,
  input  wire logic                  bit_in,
  input  wire sitoa_pkg::bcd_t       digit_in,
  output      logic                  bit_out,
  output      sitoa_pkg::bcd_t       digit_out
);

  sitoa_pkg::bcd_t digit_r;
  sitoa_pkg::bcd_t digit_nxt;
  sitoa_pkg::bcd_t adj;

  always_comb begin
    adj = (digit_r >= 4'd5) ? (digit_r + 4'd3) : digit_r;
  end

  assign bit_out   = adj[3];
  assign digit_out = digit_r;

  always_comb begin
    priority if (ctrl.clr) begin
      digit_nxt = '0;
    end else if (ctrl.dabble) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.rotate) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

`default_nettype wire

// File: rtl/core/sitoa_digit_chain.sv
// row of bcd digit cells, least significant at index 0
// depends on sitoa_pkg and sitoa_digit_cell
`default_nettype none

module sitoa_digit_chain (
  input  wire logic                  clk,
  input  wire sitoa_pkg::cell_ctrl_t ctrl,
  input  wire logic                  bit_in,
  output      sitoa_pkg::bcd_t       top_digit
);

  logic            bits   [0:sitoa_pkg::NUM_DIGITS];
  sitoa_pkg::bcd_t digits [0:sitoa_pkg::NUM_DIGITS];

  assign bits[0]   = bit_in;
  assign digits[0] = '0;

  for (genvar i = 0; i < sitoa_pkg::NUM_DIGITS; i++) begin : g_cell
    sitoa_digit_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bit_in    (bits[i]),
      .digit_in  (digits[i]),
      .bit_out   (bits[i+1]),
      .digit_out (digits[i+1])
    );
  end

  // carry out of the top cell is always zero for a 32-bit magnitude
  logic unused_carry;
  assign unused_carry = bits[sitoa_pkg::NUM_DIGITS];

  assign top_digit = digits[sitoa_pkg::NUM_DIGITS];

endmodule

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii_unit.sv
// signed 32-bit integer to decimal ascii text, one character per output transfer
// steps: accept, shift-and-adjust of every magnitude bit through the bcd digit chain,
// then an optional sign character and the digit positions (leading zeros skipped)
// a new value is taken only in idle, after the last character; output stalls hold the text
// reset: synchronous active-low rst_n returns control to idle; no text is pending
`default_nettype none
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module signed_int_to_decimal_ascii_unit (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sitoa_in_if.sink   in_ch,
  sitoa_out_if.source out_ch
);

  sitoa_pkg::state_t                      state_r, state_nxt;
  logic [sitoa_pkg::MAG_W-1:0]            mag_r, mag_nxt;
  logic                                   neg_r, neg_nxt;
  logic [sitoa_pkg::BIT_CNT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [sitoa_pkg::REM_W-1:0]            rem_r, rem_nxt;
  logic                                   seen_r, seen_nxt;
  sitoa_pkg::cell_ctrl_t                  ctrl;
  sitoa_pkg::bcd_t                        top_digit;
  logic                                   in_xfer;
  logic                                   emit;
  logic                                   step;
  logic [sitoa_pkg::MAG_W-1:0]            in_bits;

  sitoa_digit_chain u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (mag_r[sitoa_pkg::MAG_W-1]),
    .top_digit (top_digit)
  );

  assign in_bits = in_ch.value;
  assign in_ch.ready = (state_r == sitoa_pkg::ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;

  // a leading zero is dropped unless it is the only digit
  assign emit = seen_r || (top_digit != 4'd0) ||
                (rem_r == sitoa_pkg::REM_W'(1));
  assign step = (state_r == sitoa_pkg::ST_DIGITS) && (!emit || out_ch.ready);

  always_comb begin
    unique case (state_r)
      sitoa_pkg::ST_SIGN: begin
        out_ch.valid     = 1'b1;
        out_ch.character = sitoa_pkg::ASCII_MINUS;
        out_ch.last      = 1'b0;
      end
      sitoa_pkg::ST_DIGITS: begin
        out_ch.valid     = emit;
        out_ch.character = sitoa_pkg::ASCII_ZERO + {4'd0, top_digit};
        out_ch.last      = (rem_r == sitoa_pkg::REM_W'(1));
      end
      default: begin
        out_ch.valid     = 1'b0;
        out_ch.character = sitoa_pkg::ASCII_ZERO;
        out_ch.last      = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    mag_nxt     = mag_r;
    neg_nxt     = neg_r;
    bit_cnt_nxt = bit_cnt_r;
    rem_nxt     = rem_r;
    seen_nxt    = seen_r;
    ctrl        = '0;
    unique case (state_r)
      sitoa_pkg::ST_IDLE: begin
        if (in_xfer) begin
          neg_nxt     = in_bits[sitoa_pkg::MAG_W-1];
          mag_nxt     = in_bits[sitoa_pkg::MAG_W-1] ? (~in_bits + 1'b1) : in_bits;
          bit_cnt_nxt = '0;
          ctrl.clr    = 1'b1;
          state_nxt   = sitoa_pkg::ST_CONV;
        end
      end
      sitoa_pkg::ST_CONV: begin
        ctrl.dabble = 1'b1;
        mag_nxt     = {mag_r[sitoa_pkg::MAG_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        rem_nxt     = sitoa_pkg::REM_W'(sitoa_pkg::NUM_DIGITS);
        seen_nxt    = 1'b0;
        if (bit_cnt_r == sitoa_pkg::BIT_CNT_W'(sitoa_pkg::MAG_W - 1)) begin
          state_nxt = neg_r ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_DIGITS;
        end
      end
      sitoa_pkg::ST_SIGN: begin
        if (out_ch.ready) begin
          state_nxt = sitoa_pkg::ST_DIGITS;
        end
      end
      sitoa_pkg::ST_DIGITS: begin
        if (step) begin
          ctrl.rotate = 1'b1;
          rem_nxt     = rem_r - 1'b1;
          seen_nxt    = seen_r || emit;
          if (rem_r == sitoa_pkg::REM_W'(1)) begin
            state_nxt = sitoa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = sitoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sitoa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r     <= mag_nxt;
    neg_r     <= neg_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    rem_r     <= rem_nxt;
    seen_r    <= seen_nxt;
  end

  // no new value while text is still pending
  `SITOA_ASSERT_SAME(a_no_accept_while_out, clk, rst_n, out_ch.valid, !in_ch.ready)
  // final character transfer returns to idle
  `SITOA_ASSERT_NEXT(a_last_to_idle, clk, rst_n,
    out_ch.valid && out_ch.ready && out_ch.last, state_r == sitoa_pkg::ST_IDLE)
  // first digit of a multi-digit number is never zero
  `SITOA_ASSERT_SAME(a_no_leading_zero, clk, rst_n,
    out_ch.valid && !out_ch.last && (state_r == sitoa_pkg::ST_DIGITS) && !seen_r,
    top_digit != 4'd0)
  // an accepted value starts the conversion
  `SITOA_ASSERT_NEXT(a_accept_to_conv, clk, rst_n, in_xfer,
    state_r == sitoa_pkg::ST_CONV)

endmodule

`default_nettype wire
